>>> rtl/asgc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asgc_pkg
// Shared types and constants of the sample to s16 gain converter: register
// indexes, format and opcode codes, float and saturation constants, and the
// command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package asgc_pkg;

  localparam int MAX_CHANNELS_DEF = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FMT_W      = 2;
  localparam int CH_CFG_W   = 4;
  localparam int GAIN_W     = 16;
  localparam int WORD_W     = 32;
  localparam int SAMPLE_W   = 16;
  localparam int CHAN_W     = 3;
  localparam int INT_MAG_W  = 17;
  localparam int MUL_A_W    = 24;
  localparam int PROD_W     = MUL_A_W + GAIN_W;
  localparam int SCALE_SH   = 15;
  localparam int SCALED_W   = PROD_W + SCALE_SH;
  localparam int GAIN_FRAC  = 12;
  localparam int INT_RES_W  = 21;
  localparam int EXP_W      = 8;
  localparam int MAN_W      = 23;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FORMAT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CHANNELS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q12        = 2'd3;

  localparam logic [FMT_W-1:0] FMT_PCM16   = 2'd0;
  localparam logic [FMT_W-1:0] FMT_PCM32   = 2'd1;
  localparam logic [FMT_W-1:0] FMT_FLOAT32 = 2'd2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_SILENT = 1'b1;

  localparam logic [FMT_W-1:0]    RST_SOURCE_FORMAT   = FMT_PCM16;
  localparam logic [CH_CFG_W-1:0] RST_SOURCE_CHANNELS = 4'd2;
  localparam logic [CH_CFG_W-1:0] RST_OUTPUT_CHANNELS = 4'd2;
  localparam logic [GAIN_W-1:0]   GAIN_UNITY          = 16'd4096;
  localparam logic [GAIN_W-1:0]   GAIN_BYPASS_LO      = 16'd4092;
  localparam logic [GAIN_W-1:0]   GAIN_BYPASS_HI      = 16'd4100;

  localparam logic [EXP_W-1:0] FLT_EXP_SPECIAL = 8'hFF;
  localparam logic [EXP_W-1:0] FLT_SAT_EXP     = 8'd162;

  localparam logic [SAMPLE_W-1:0]  S16_POS_MAG = 16'd32767;
  localparam logic [INT_RES_W-1:0] INT_POS_LIM = 21'd32767;
  localparam logic [INT_RES_W-1:0] INT_NEG_LIM = 21'd32768;

  typedef struct packed {
    logic [FMT_W-1:0]    fmt;
    logic [CH_CFG_W-1:0] src_ch;
    logic [CH_CFG_W-1:0] out_ch;
    logic [GAIN_W-1:0]   gain;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_WRITE,
    ST_SILENT
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic mul;
    logic scale;
    logic load_sample;
    logic load_silent;
  } ctrl_cmd_t;

  typedef struct packed {
    logic silent_op;
    logic keep;
    logic out_free;
    logic silent_last;
  } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/asgc_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asgc_cfg_regs
// Configuration register file: format, channel counts and gain, written
// through a plain indexed write port.
// ----------------------------------------------------------------------------
module asgc_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [asgc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [asgc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output asgc_pkg::cfg_t                        cfg_o
);
  import asgc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt    <= RST_SOURCE_FORMAT;
      cfg_q.src_ch <= RST_SOURCE_CHANNELS;
      cfg_q.out_ch <= RST_OUTPUT_CHANNELS;
      cfg_q.gain   <= GAIN_UNITY;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SOURCE_FORMAT:   cfg_q.fmt    <= cfg_data_i[FMT_W-1:0];
        REG_SOURCE_CHANNELS: cfg_q.src_ch <= cfg_data_i[CH_CFG_W-1:0];
        REG_OUTPUT_CHANNELS: cfg_q.out_ch <= cfg_data_i[CH_CFG_W-1:0];
        REG_GAIN_Q12:        cfg_q.gain   <= cfg_data_i[GAIN_W-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> rtl/asgc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asgc_ctrl
// Controller: sequences one word through multiply, scale and write, or walks
// a silent frame out one zero per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module asgc_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  asgc_pkg::dp_status_t stat_i,
  output asgc_pkg::ctrl_cmd_t  cmd_o,
  output logic                 in_stall_o
);
  import asgc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.silent_op) begin
            state_d = ST_SILENT;
          end else if (stat_i.keep) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_WRITE;
      ST_WRITE: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SILENT: begin
        if (stat_i.out_free && stat_i.silent_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_MUL:    cmd_o.mul = 1'b1;
      ST_SCALE:  cmd_o.scale = 1'b1;
      ST_WRITE:  cmd_o.load_sample = stat_i.out_free;
      ST_SILENT: cmd_o.load_silent = stat_i.out_free;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_kept_word_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && !stat_i.silent_op && stat_i.keep)
      |=> (state_q == ST_MUL) ##1 (state_q == ST_SCALE) ##1 (state_q == ST_WRITE))
    else $error("kept word did not pass multiply, scale and write in order");
`endif

endmodule
`default_nettype wire

>>> rtl/asgc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asgc_datapath
// Datapath: channel position and silent-frame counters, shared gain
// multiplier, float scale by 32767, final shift and saturation, and the
// output register.
// ----------------------------------------------------------------------------
module asgc_datapath #(
  parameter int MAX_CHANNELS = asgc_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  asgc_pkg::cfg_t                      cfg_i,
  input  wire logic                           opcode_i,
  input  wire logic [asgc_pkg::WORD_W-1:0]    sample_word_i,
  input  asgc_pkg::ctrl_cmd_t                 cmd_i,
  output asgc_pkg::dp_status_t                stat_o,
  input  wire logic                           out_stall_i,
  output logic                                out_valid_o,
  output logic signed [asgc_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic [asgc_pkg::CHAN_W-1:0]         channel_o,
  output logic                                last_o
);
  import asgc_pkg::*;

  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int POS_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int WIDE_W = (CNT_W > CH_CFG_W) ? CNT_W : CH_CFG_W;

  logic [CNT_W-1:0]  src_cnt, dst_cnt, kept_cnt, pos_inc, sil_inc;
  logic [WIDE_W-1:0] max_wide;
  logic [POS_W-1:0]  pos_q, pos_d, sil_q, sil_d;
  logic [GAIN_W-1:0] gain_eff;

  logic [WORD_W-1:0] word_q;
  logic [CHAN_W-1:0] chan_q;

  logic [SAMPLE_W-1:0]  int_h;
  logic                 int_neg;
  logic [INT_MAG_W-1:0] int_abs;
  logic [EXP_W-1:0]     flt_exp, flt_ex;
  logic [MAN_W-1:0]     flt_man;
  logic [MUL_A_W-1:0]   mul_a;
  logic                 flt_fmt;

  logic [PROD_W-1:0]   prod_q;
  logic [FMT_W-1:0]    fmt_q;
  logic                neg_q, nan_q, inf_q, big_exp_q, gain_zero_q;
  logic [EXP_W-1:0]    shamt_q;
  logic [SCALED_W-1:0] scaled_q, scaled_d, shifted;
  logic                sat_q;

  logic [INT_RES_W-1:0] int_mag;
  logic [SAMPLE_W-1:0]  mag_sel, result;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_sample_q;
  logic [CHAN_W-1:0]   out_chan_q;
  logic                out_last_q;
  logic                out_free;

  // channel counts clamped to 1..MAX_CHANNELS
  assign max_wide = WIDE_W'(MAX_CHANNELS);

  always_comb begin
    if (cfg_i.src_ch == '0) begin
      src_cnt = CNT_W'(1);
    end else if (WIDE_W'(cfg_i.src_ch) > max_wide) begin
      src_cnt = CNT_W'(MAX_CHANNELS);
    end else begin
      src_cnt = CNT_W'(cfg_i.src_ch);
    end
    if (cfg_i.out_ch == '0) begin
      dst_cnt = CNT_W'(1);
    end else if (WIDE_W'(cfg_i.out_ch) > max_wide) begin
      dst_cnt = CNT_W'(MAX_CHANNELS);
    end else begin
      dst_cnt = CNT_W'(cfg_i.out_ch);
    end
    kept_cnt = (src_cnt < dst_cnt) ? src_cnt : dst_cnt;
  end

  assign gain_eff = ((cfg_i.gain >= GAIN_BYPASS_LO) && (cfg_i.gain <= GAIN_BYPASS_HI)) ?
                    GAIN_UNITY : cfg_i.gain;

  // position and silent-frame counters
  assign pos_inc = CNT_W'(pos_q) + CNT_W'(1);
  assign sil_inc = CNT_W'(sil_q) + CNT_W'(1);

  always_comb begin
    pos_d = pos_q;
    sil_d = sil_q;
    if (cmd_i.accept) begin
      sil_d = '0;
      if (opcode_i == OP_SAMPLE) begin
        pos_d = (pos_inc >= src_cnt) ? '0 : POS_W'(pos_inc);
      end
    end else if (cmd_i.load_silent) begin
      sil_d = POS_W'(sil_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sil_q <= '0;
    end else begin
      pos_q <= pos_d;
      sil_q <= sil_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      word_q <= sample_word_i;
      chan_q <= CHAN_W'(pos_q);
    end
  end

  // multiply stage operands
  assign flt_fmt  = (cfg_i.fmt == FMT_FLOAT32);
  assign int_h    = (cfg_i.fmt == FMT_PCM32) ? word_q[WORD_W-1:SAMPLE_W] :
                                               word_q[SAMPLE_W-1:0];
  assign int_neg  = int_h[SAMPLE_W-1];
  assign int_abs  = int_neg ? (INT_MAG_W'(0) - {int_h[SAMPLE_W-1], int_h}) : {1'b0, int_h};
  assign flt_exp  = word_q[WORD_W-2 -: EXP_W];
  assign flt_man  = word_q[MAN_W-1:0];
  assign flt_ex   = (flt_exp != '0) ? flt_exp : EXP_W'(1);
  assign mul_a    = flt_fmt ? {(flt_exp != '0), flt_man} : MUL_A_W'(int_abs);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q      <= PROD_W'(mul_a) * PROD_W'(gain_eff);
      fmt_q       <= cfg_i.fmt;
      neg_q       <= flt_fmt ? word_q[WORD_W-1] : int_neg;
      nan_q       <= (flt_exp == FLT_EXP_SPECIAL) && (flt_man != '0);
      inf_q       <= (flt_exp == FLT_EXP_SPECIAL) && (flt_man == '0);
      big_exp_q   <= (flt_ex >= FLT_SAT_EXP);
      shamt_q     <= FLT_SAT_EXP - flt_ex;
      gain_zero_q <= (gain_eff == '0);
    end
  end

  // scale stage: for float32 p * 32767 as (p << 15) - p, and the magnitude-one check
  always_comb begin
    if (fmt_q == FMT_FLOAT32) begin
      scaled_d = {prod_q, {SCALE_SH{1'b0}}} - SCALED_W'(prod_q);
    end else begin
      scaled_d = SCALED_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      scaled_q <= scaled_d;
      sat_q    <= (prod_q != '0) && (big_exp_q || ((prod_q >> shamt_q) != '0));
    end
  end

  // write stage: final shift, saturation and sign
  assign shifted = scaled_q >> shamt_q;
  assign int_mag = scaled_q[GAIN_FRAC +: INT_RES_W];

  always_comb begin
    mag_sel = '0;
    case (fmt_q)
      FMT_PCM16, FMT_PCM32: begin
        if (neg_q) begin
          mag_sel = (int_mag > INT_NEG_LIM) ? SAMPLE_W'(INT_NEG_LIM) : SAMPLE_W'(int_mag);
        end else begin
          mag_sel = (int_mag > INT_POS_LIM) ? S16_POS_MAG : SAMPLE_W'(int_mag);
        end
      end
      FMT_FLOAT32: begin
        if (nan_q) begin
          mag_sel = '0;
        end else if (inf_q) begin
          mag_sel = gain_zero_q ? '0 : S16_POS_MAG;
        end else if (sat_q) begin
          mag_sel = S16_POS_MAG;
        end else begin
          mag_sel = SAMPLE_W'(shifted);
        end
      end
      default: mag_sel = '0;
    endcase
    result = neg_q ? (~mag_sel + SAMPLE_W'(1)) : mag_sel;
  end

  // output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_sample || cmd_i.load_silent) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      out_sample_q <= result;
      out_chan_q   <= chan_q;
      out_last_q   <= 1'b1;
    end else if (cmd_i.load_silent) begin
      out_sample_q <= '0;
      out_chan_q   <= CHAN_W'(sil_q);
      out_last_q   <= (sil_inc == dst_cnt);
    end
  end

  assign stat_o.silent_op   = (opcode_i == OP_SILENT);
  assign stat_o.keep        = (CNT_W'(pos_q) < kept_cnt);
  assign stat_o.out_free    = out_free;
  assign stat_o.silent_last = (sil_inc == dst_cnt);

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign channel_o    = out_chan_q;
  assign last_o       = out_last_q;

`ifndef SYNTHESIS
  a_float_unsat_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_sample && (fmt_q == FMT_FLOAT32) && !nan_q && !inf_q && !sat_q)
      |-> (shifted[SCALED_W-1:SCALE_SH] == '0) &&
          (shifted[SCALE_SH-1:0] != S16_POS_MAG[SCALE_SH-1:0]))
    else $error("unsaturated float magnitude reached full scale");

  a_sample_word_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_sample |=> (out_valid_q && out_last_q && (out_chan_q == $past(chan_q))))
    else $error("sample result lost its channel or last flag");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(cmd_i.load_sample || cmd_i.load_silent))
    else $error("output register overwritten while stalled");
`endif

endmodule
`default_nettype wire

>>> rtl/audio_sample_to_s16_gain_converter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// audio_sample_to_s16_gain_converter_core
// Converts interleaved PCM16, PCM32 or float32 samples to signed 16-bit
// with a Q12 gain, dropping source channels beyond the output count.
// ----------------------------------------------------------------------------
// A kept sample word is accepted, then passes the gain multiply, the scale (by
// 32767 for float32) and the final shift and saturation before its result enters
// the output register; the controller steps it through the single shared
// multiplier datapath, and a stalled output lengthens the last step. A sample
// word on a dropped channel is taken and gives no result. A silent-frame word
// is taken and then gives one zero per output channel. The next word is accepted
// while the previous result still waits in the output register.
// Configuration writes belong to idle periods only.
module audio_sample_to_s16_gain_converter_core #(
  parameter int MAX_CHANNELS = asgc_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [asgc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [asgc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            opcode_i,
  input  wire logic [asgc_pkg::WORD_W-1:0]     sample_word_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [asgc_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic [asgc_pkg::CHAN_W-1:0]          channel_o,
  output logic                                 last_o
);
  import asgc_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t stat;

  asgc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  asgc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  asgc_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .opcode_i      (opcode_i),
    .sample_word_i (sample_word_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .sample_out_o  (sample_out_o),
    .channel_o     (channel_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire
